FILE: hdl/bsw_pkg.sv
package bsw_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int WEIGHT_BITS     = 24;
	localparam int WEIGHT_W        = WEIGHT_BITS + 1;
	localparam int OUT_WEIGHT_BITS = 24;
	localparam int FRONT_STAGES    = 7;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;

	// scaled position is held wide enough that the base index keeps 33 bits
	localparam int T_W    = (2 * FRAC_BITS + 33 > 65) ? 2 * FRAC_BITS + 33 : 65;
	localparam int BASE_W = T_W - 2 * FRAC_BITS;

	localparam logic [1:0] LAST_TAP = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 3'd4;

	typedef logic [FRONT_STAGES-1:0] stage_vec_t;

	typedef struct packed {
		logic [2:0][31:0]         idx;
		logic [2:0][31:0]         np;
		logic [2:0][31:0]         off;
		logic [2:0][WEIGHT_W-1:0] w;
		logic                     bad;
	} axis_rec_t;

endpackage

FILE: hdl/bsw_axis.sv
module bsw_axis (
	input  logic                clk,
	input  bsw_pkg::stage_vec_t load,
	input  logic [31:0]         pos,
	input  logic [31:0]         org,
	input  logic [30:0]         inv_spacing,
	input  logic [30:0]         spacing,
	output bsw_pkg::axis_rec_t  rec
);
	import bsw_pkg::*;

	localparam int F2 = 2 * FRAC_BITS;
	localparam logic [T_W-1:0]      HALF   = T_W'(1) << (F2 - 1);
	localparam logic [WEIGHT_W-1:0] ONE    = WEIGHT_W'(1) << WEIGHT_BITS;
	localparam logic [WEIGHT_W-1:0] HALF_W = WEIGHT_W'(1) << (WEIGHT_BITS - 1);

	// stage 1: shift by origin
	logic [32:0] d_s1;
	logic [31:0] pos_s1;

	always_ff @(posedge clk) begin
		if (load[0]) begin
			d_s1   <= {pos[31], pos} - {org[31], org};
			pos_s1 <= pos;
		end
	end

	// stage 2: scale to grid units, Q.2F
	logic signed [64:0] mul_d;
	logic [63:0]        prod_s2;
	logic [31:0]        pos_s2;

	assign mul_d = $signed(d_s1) * $signed({1'b0, inv_spacing});

	always_ff @(posedge clk) begin
		if (load[1]) begin
			prod_s2 <= mul_d[63:0];
			pos_s2  <= pos_s1;
		end
	end

	// stage 3: base = floor(n - 0.5), fraction u truncated to weight precision
	logic [T_W-1:0]                 t;
	logic [BASE_W-1:0]              base;
	logic [F2+WEIGHT_BITS-1:0]      uwx;
	logic [BASE_W-32:0]             base_hi;
	logic                           idx_bad;
	logic [WEIGHT_BITS-1:0]         uw_s3;
	logic [31:0]                    base_s3;
	logic                           ibad_s3;
	logic [31:0]                    pos_s3;

	assign t       = {{(T_W - 64){prod_s2[63]}}, prod_s2} - HALF;
	assign base    = t[T_W-1:F2];
	assign uwx     = {t[F2-1:0], WEIGHT_BITS'(0)} >> F2;
	assign base_hi = base[BASE_W-1:31];
	// base + 2 must still fit a signed word
	assign idx_bad = !((&base_hi) || !(|base_hi)) || (!base[31] && (&base[30:1]));

	always_ff @(posedge clk) begin
		if (load[2]) begin
			uw_s3   <= uwx[WEIGHT_BITS-1:0];
			base_s3 <= base[31:0];
			ibad_s3 <= idx_bad;
			pos_s3  <= pos_s2;
		end
	end

	// stage 4: squares for outer weights, base node position
	logic [WEIGHT_W-1:0]     a;
	logic [2*WEIGHT_W-1:0]   sq_a;
	logic [2*WEIGHT_W-1:0]   sq_u;
	logic signed [63:0]      pm;
	logic [WEIGHT_W-1:0]     w0_s4;
	logic [WEIGHT_W-1:0]     w2_s4;
	logic [63:0]             pm_s4;
	logic [31:0]             base_s4;
	logic                    ibad_s4;
	logic [31:0]             pos_s4;

	assign a    = ONE - {1'b0, uw_s3};
	assign sq_a = a * a;
	assign sq_u = {1'b0, uw_s3} * {1'b0, uw_s3};
	assign pm   = $signed(base_s3) * $signed({1'b0, spacing});

	always_ff @(posedge clk) begin
		if (load[3]) begin
			w0_s4   <= (uw_s3 == '0) ? HALF_W : sq_a[2*WEIGHT_W-1:WEIGHT_BITS+1];
			w2_s4   <= sq_u[2*WEIGHT_W-1:WEIGHT_BITS+1];
			pm_s4   <= pm;
			base_s4 <= base_s3;
			ibad_s4 <= ibad_s3;
			pos_s4  <= pos_s3;
		end
	end

	// stage 5: middle weight closes the sum to one, add origin
	logic [2:0][WEIGHT_W-1:0] w_s5;
	logic [63:0]              np0_s5;
	logic [31:0]              base_s5;
	logic                     ibad_s5;
	logic [31:0]              pos_s5;

	always_ff @(posedge clk) begin
		if (load[4]) begin
			w_s5[0] <= w0_s4;
			w_s5[1] <= ONE - w0_s4 - w2_s4;
			w_s5[2] <= w2_s4;
			np0_s5  <= {{32{org[31]}}, org} + pm_s4;
			base_s5 <= base_s4;
			ibad_s5 <= ibad_s4;
			pos_s5  <= pos_s4;
		end
	end

	// stage 6: three node positions
	logic [2:0][63:0]         np_s6;
	logic [2:0][WEIGHT_W-1:0] w_s6;
	logic [31:0]              base_s6;
	logic                     ibad_s6;
	logic [31:0]              pos_s6;

	always_ff @(posedge clk) begin
		if (load[5]) begin
			np_s6[0] <= np0_s5;
			np_s6[1] <= np0_s5 + {33'b0, spacing};
			np_s6[2] <= np0_s5 + {32'b0, spacing, 1'b0};
			w_s6     <= w_s5;
			base_s6  <= base_s5;
			ibad_s6  <= ibad_s5;
			pos_s6   <= pos_s5;
		end
	end

	// stage 7: offsets and range checks
	logic [2:0][32:0] off33;
	logic [2:0]       np_ok;
	logic [2:0]       off_ok;
	axis_rec_t        rec_d;
	axis_rec_t        rec_s7;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			np_ok[k]      = (&np_s6[k][63:31]) || !(|np_s6[k][63:31]);
			off33[k]      = {np_s6[k][31], np_s6[k][31:0]} - {pos_s6[31], pos_s6};
			off_ok[k]     = (off33[k][32] == off33[k][31]);
			rec_d.idx[k]  = base_s6 + 32'(k);
			rec_d.np[k]   = np_s6[k][31:0];
			rec_d.off[k]  = off33[k][31:0];
		end
		rec_d.w   = w_s6;
		rec_d.bad = ibad_s6 || !(&np_ok) || !(&off_ok);
	end

	always_ff @(posedge clk) begin
		if (load[6]) begin
			rec_s7 <= rec_d;
		end
	end

	assign rec = rec_s7;

endmodule

FILE: hdl/bspline_stencil_weights.sv
// channel | direction | handshake          | word
// --------+-----------+--------------------+---------------------------------------------
// cfg     | in        | cfg_we             | cfg_idx, cfg_data
// in      | in        | in_valid, in_stall | pos_x, pos_y, pos_z
// out     | out       | out_valid, out_stall | node index, node position, offset, weight,
//         |           |                    | last, out_of_range
//
// A particle gives 27 stencil samples at the output port, one per cycle while out_stall is
// low; a particle that overflows gives a single flagged sample. The output port sets the
// sustained rate. From accept to the first sample a particle passes seven per-axis stages,
// then the two weight product stages, the second of which is the output register.
// Reset clears all valid bits and the sample counter and loads origin 0, spacing 1.0.
// out_stall holds the output word; the stages behind fill up and in_stall rises once
// every stage holds a word.
module bspline_stencil_weights (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bsw_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [bsw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [31:0]                        pos_x,
	input  logic [31:0]                        pos_y,
	input  logic [31:0]                        pos_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [31:0]                        node_ix,
	output logic [31:0]                        node_iy,
	output logic [31:0]                        node_iz,
	output logic [31:0]                        node_px,
	output logic [31:0]                        node_py,
	output logic [31:0]                        node_pz,
	output logic [31:0]                        offset_x,
	output logic [31:0]                        offset_y,
	output logic [31:0]                        offset_z,
	output logic [bsw_pkg::OUT_WEIGHT_BITS:0]  weight,
	output logic                               last,
	output logic                               out_of_range
);
	import bsw_pkg::*;

	localparam int SH_R = (WEIGHT_BITS >= OUT_WEIGHT_BITS) ? WEIGHT_BITS - OUT_WEIGHT_BITS : 0;
	localparam int SH_L = (WEIGHT_BITS >= OUT_WEIGHT_BITS) ? 0 : OUT_WEIGHT_BITS - WEIGHT_BITS;
	localparam logic [30:0] UNIT = 31'(1) << FRAC_BITS;

	// configuration registers
	logic [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic [30:0] spacing_q, inv_spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			origin_z_q    <= '0;
			spacing_q     <= UNIT;
			inv_spacing_q <= UNIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ORIGIN_X:    origin_x_q    <= cfg_data;
				REG_ORIGIN_Y:    origin_y_q    <= cfg_data;
				REG_ORIGIN_Z:    origin_z_q    <= cfg_data;
				REG_SPACING:     spacing_q     <= cfg_data[30:0];
				REG_INV_SPACING: inv_spacing_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// flow control
	stage_vec_t front_v_q;
	stage_vec_t take;
	stage_vec_t load;
	logic       valid_s8, valid_s9;
	logic       take_s8, take_s9;
	logic       issue, final_smp, bad;
	logic [1:0] ci_q, cj_q, cl_q;
	axis_rec_t  rec_x, rec_y, rec_z;

	assign take_s9   = !valid_s9 || !out_stall;
	assign take_s8   = !valid_s8 || take_s9;
	assign issue     = front_v_q[FRONT_STAGES-1] && take_s8;
	assign bad       = rec_x.bad || rec_y.bad || rec_z.bad;
	assign final_smp = bad || (ci_q == LAST_TAP && cj_q == LAST_TAP && cl_q == LAST_TAP);

	always_comb begin
		take[FRONT_STAGES-1] = !front_v_q[FRONT_STAGES-1] || (issue && final_smp);
		for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
			take[k] = !front_v_q[k] || take[k+1];
		end
		load[0] = in_valid && take[0];
		for (int k = 1; k < FRONT_STAGES; k++) begin
			load[k] = front_v_q[k-1] && take[k];
		end
	end

	assign in_stall  = !take[0];
	assign out_valid = valid_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_q <= '0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
		end else begin
			if (take[0]) begin
				front_v_q[0] <= in_valid;
			end
			for (int k = 1; k < FRONT_STAGES; k++) begin
				if (take[k]) begin
					front_v_q[k] <= front_v_q[k-1];
				end
			end
			if (take_s8) begin
				valid_s8 <= issue;
			end
			if (take_s9) begin
				valid_s9 <= valid_s8;
			end
		end
	end

	// stencil walk, z innermost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
			cj_q <= '0;
			cl_q <= '0;
		end else if (issue) begin
			if (final_smp) begin
				ci_q <= '0;
				cj_q <= '0;
				cl_q <= '0;
			end else if (cl_q != LAST_TAP) begin
				cl_q <= cl_q + 2'd1;
			end else begin
				cl_q <= '0;
				if (cj_q != LAST_TAP) begin
					cj_q <= cj_q + 2'd1;
				end else begin
					cj_q <= '0;
					ci_q <= ci_q + 2'd1;
				end
			end
		end
	end

	bsw_axis u_ax (
		.clk         (clk),
		.load        (load),
		.pos         (pos_x),
		.org         (origin_x_q),
		.inv_spacing (inv_spacing_q),
		.spacing     (spacing_q),
		.rec         (rec_x)
	);

	bsw_axis u_ay (
		.clk         (clk),
		.load        (load),
		.pos         (pos_y),
		.org         (origin_y_q),
		.inv_spacing (inv_spacing_q),
		.spacing     (spacing_q),
		.rec         (rec_y)
	);

	bsw_axis u_az (
		.clk         (clk),
		.load        (load),
		.pos         (pos_z),
		.org         (origin_z_q),
		.inv_spacing (inv_spacing_q),
		.spacing     (spacing_q),
		.rec         (rec_z)
	);

	// stage 8: pick the sample, first weight product
	logic [WEIGHT_W-1:0]   wx, wy, wz;
	logic [2*WEIGHT_W-1:0] pxy;
	logic [31:0]           ix_s8, iy_s8, iz_s8, px_s8, py_s8, pz_s8, ox_s8, oy_s8, oz_s8;
	logic [WEIGHT_W-1:0]   m_s8, wz_s8;
	logic                  last_s8, oor_s8;

	// an overflowed particle gives zero weights and fields
	assign wx  = bad ? '0 : rec_x.w[ci_q];
	assign wy  = bad ? '0 : rec_y.w[cj_q];
	assign wz  = bad ? '0 : rec_z.w[cl_q];
	assign pxy = wx * wy;

	always_ff @(posedge clk) begin
		if (issue) begin
			ix_s8   <= bad ? '0 : rec_x.idx[ci_q];
			iy_s8   <= bad ? '0 : rec_y.idx[cj_q];
			iz_s8   <= bad ? '0 : rec_z.idx[cl_q];
			px_s8   <= bad ? '0 : rec_x.np[ci_q];
			py_s8   <= bad ? '0 : rec_y.np[cj_q];
			pz_s8   <= bad ? '0 : rec_z.np[cl_q];
			ox_s8   <= bad ? '0 : rec_x.off[ci_q];
			oy_s8   <= bad ? '0 : rec_y.off[cj_q];
			oz_s8   <= bad ? '0 : rec_z.off[cl_q];
			m_s8    <= pxy[WEIGHT_BITS +: WEIGHT_W];
			wz_s8   <= wz;
			last_s8 <= final_smp && !bad;
			oor_s8  <= bad;
		end
	end

	// stage 9: second product, rescale to Q1.24, output register
	logic [2*WEIGHT_W-1:0]                 pxyz;
	logic [2*WEIGHT_W+OUT_WEIGHT_BITS-1:0] cw;
	logic [31:0]           ix_s9, iy_s9, iz_s9, px_s9, py_s9, pz_s9, ox_s9, oy_s9, oz_s9;
	logic [OUT_WEIGHT_BITS:0] weight_s9;
	logic                  last_s9, oor_s9;

	assign pxyz = m_s8 * wz_s8;
	assign cw   = ({{OUT_WEIGHT_BITS{1'b0}}, pxyz} >> (WEIGHT_BITS + SH_R)) << SH_L;

	always_ff @(posedge clk) begin
		if (take_s9 && valid_s8) begin
			ix_s9     <= ix_s8;
			iy_s9     <= iy_s8;
			iz_s9     <= iz_s8;
			px_s9     <= px_s8;
			py_s9     <= py_s8;
			pz_s9     <= pz_s8;
			ox_s9     <= ox_s8;
			oy_s9     <= oy_s8;
			oz_s9     <= oz_s8;
			weight_s9 <= cw[OUT_WEIGHT_BITS:0];
			last_s9   <= last_s8;
			oor_s9    <= oor_s8;
		end
	end

	assign node_ix      = ix_s9;
	assign node_iy      = iy_s9;
	assign node_iz      = iz_s9;
	assign node_px      = px_s9;
	assign node_py      = py_s9;
	assign node_pz      = pz_s9;
	assign offset_x     = ox_s9;
	assign offset_y     = oy_s9;
	assign offset_z     = oz_s9;
	assign weight       = weight_s9;
	assign last         = last_s9;
	assign out_of_range = oor_s9;

endmodule

FILE: hdl/bsw_checker.sv
module bsw_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [31:0]                        pos_x,
	input logic [31:0]                        pos_y,
	input logic [31:0]                        pos_z,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [31:0]                        node_ix,
	input logic [31:0]                        node_iy,
	input logic [31:0]                        node_iz,
	input logic [31:0]                        node_px,
	input logic [31:0]                        node_py,
	input logic [31:0]                        node_pz,
	input logic [31:0]                        offset_x,
	input logic [31:0]                        offset_y,
	input logic [31:0]                        offset_z,
	input logic [bsw_pkg::OUT_WEIGHT_BITS:0]  weight,
	input logic                               last,
	input logic                               out_of_range
);
	import bsw_pkg::*;

	localparam logic [OUT_WEIGHT_BITS:0] W_ONE = (OUT_WEIGHT_BITS + 1)'(1) << OUT_WEIGHT_BITS;

	// a flagged word carries nothing else
	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> !last && weight == '0 && node_ix == '0 &&
			node_iy == '0 && node_iz == '0 && node_px == '0 && node_py == '0 &&
			node_pz == '0 && offset_x == '0 && offset_y == '0 && offset_z == '0)
		else $error("flagged word carries non-zero fields");

	// a product of three partition-of-unity weights never exceeds one
	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weight <= W_ONE)
		else $error("weight above one");

	// hold a stalled input word until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(pos_x) && $stable(pos_y) &&
			$stable(pos_z))
		else $error("stalled input word changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(node_ix) && $stable(node_iy) &&
			$stable(node_iz) && $stable(node_px) && $stable(node_py) &&
			$stable(node_pz) && $stable(offset_x) && $stable(offset_y) &&
			$stable(offset_z) && $stable(weight) && $stable(last) &&
			$stable(out_of_range))
		else $error("stalled output word changed");

endmodule

bind bspline_stencil_weights bsw_checker u_bsw_checker (.*);

FILE: tb/tb_bspline_stencil_weights.sv
module tb_bspline_stencil_weights;
	import bsw_pkg::*;

	localparam int STENCIL     = 27;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 240;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint unsigned W_ONE  = 64'd1 << WEIGHT_BITS;
	localparam longint unsigned N_HALF = 64'd1 << (2 * FRAC_BITS - 1);
	localparam longint unsigned N_FRAC = (64'd1 << (2 * FRAC_BITS)) - 1;

	typedef struct packed {
		logic [8:0][31:0]         geo;  // ix iy iz, px py pz, ox oy oz
		logic [OUT_WEIGHT_BITS:0] wgt;
		logic                     lst;
		logic                     oor;
	} sample_t;

	typedef enum logic {ROW_CALC, ROW_OVERFLOW} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} drow_t;

	typedef struct packed {
		logic [31:0] ox;
		logic [31:0] oy;
		logic [31:0] oz;
		logic [30:0] sp;
		logic [30:0] inv;
		logic [7:0]  idle;
		logic [7:0]  stall;
		logic [15:0] items;
		logic        hold;
		logic        pause;
		logic [4:0]  spread;
	} phase_t;

	// reset grid: one node per metre at the origin
	localparam int NUM_ROWS = 21;
	localparam drow_t DIR_ROWS [0:NUM_ROWS-1] = '{
		'{ROW_CALC,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
		'{ROW_CALC,     32'h0000_8000, 32'h0000_8000, 32'h0000_8000},  // halfway between two nodes
		'{ROW_CALC,     32'h0000_7FFF, 32'h0000_8001, 32'h0000_FFFF},
		'{ROW_CALC,     32'h0001_0000, 32'h0001_8000, 32'h0002_C000},
		'{ROW_CALC,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{ROW_CALC,     32'h0000_0001, 32'hFFFF_8000, 32'h0001_8000},
		'{ROW_CALC,     32'h7FFD_0000, 32'h7FFE_7FFF, 32'h0000_0000},
		'{ROW_OVERFLOW, 32'h7FFE_8000, 32'h0000_0000, 32'h0000_0000},
		'{ROW_CALC,     32'h8001_0000, 32'h8000_8000, 32'h8001_8000},
		'{ROW_OVERFLOW, 32'h0000_0000, 32'h8000_7FFF, 32'h0000_0000},
		'{ROW_OVERFLOW, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000},
		'{ROW_OVERFLOW, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000},
		'{ROW_OVERFLOW, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF},
		'{ROW_OVERFLOW, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
		'{ROW_OVERFLOW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
		'{ROW_CALC,     32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333},
		'{ROW_CALC,     32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC},
		'{ROW_CALC,     32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F},
		'{ROW_CALC,     32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0001},
		'{ROW_CALC,     32'h7FFE_7FFF, 32'h8000_8000, 32'h7FFD_0000},
		'{ROW_OVERFLOW, 32'h1234_5678, 32'h1234_5678, 32'h8000_7FFF}
	};

	localparam int NUM_PHASES = 6;
	localparam phase_t PHASES [0:NUM_PHASES-1] = '{
		'{32'h0001_2345, 32'hFFFE_8000, 32'h0000_0000, 31'h0000_8000, 31'h0002_0000,
			8'd77, 8'd0, 16'd45, 1'b0, 1'b0, 5'd22},
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 31'h0000_0001, 31'h7FFF_FFFF,
			8'd0, 8'd77, 16'd25, 1'b0, 1'b0, 5'd12},
		'{32'hFFF0_0000, 32'h000A_0000, 32'h1234_5678, 31'h0000_4000, 31'h0004_0000,
			8'd32, 8'd32, 16'd50, 1'b1, 1'b0, 5'd20},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0001,
			8'd0, 8'd77, 16'd15, 1'b0, 1'b0, 5'd8},
		// zero spacing and reciprocal: every node sits on the origin
		'{32'h0005_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_0000, 31'h0000_0000,
			8'd0, 8'd0, 16'd20, 1'b0, 1'b1, 5'd24},
		'{32'h0123_4567, 32'hFEDC_BA98, 32'h5555_5555, 31'h0003_0000, 31'h0000_5555,
			8'd0, 8'd0, 16'd45, 1'b0, 1'b0, 5'd26}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] pos_x = '0;
	logic [31:0] pos_y = '0;
	logic [31:0] pos_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] node_ix, node_iy, node_iz;
	logic [31:0] node_px, node_py, node_pz;
	logic [31:0] offset_x, offset_y, offset_z;
	logic [OUT_WEIGHT_BITS:0] weight;
	logic last;
	logic out_of_range;

	// grid registers as the predictor sees them
	logic [31:0] org_q [0:2];
	logic [30:0] sp_q;
	logic [30:0] inv_q;

	sample_t stencil_q [$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	string geo_name [0:8] = '{"node_ix", "node_iy", "node_iz", "node_px", "node_py",
		"node_pz", "offset_x", "offset_y", "offset_z"};

	bspline_stencil_weights dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.node_ix(node_ix),
		.node_iy(node_iy),
		.node_iz(node_iz),
		.node_px(node_px),
		.node_py(node_py),
		.node_pz(node_pz),
		.offset_x(offset_x),
		.offset_y(offset_y),
		.offset_z(offset_z),
		.weight(weight),
		.last(last),
		.out_of_range(out_of_range)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit fits32(input longint v);
		return v == longint'($signed(v[31:0]));
	endfunction

	task automatic compute_stencil(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz);
		logic [31:0] pin [0:2];
		longint pos [0:2];
		longint idx [0:2][0:2];
		longint np [0:2][0:2];
		longint off [0:2][0:2];
		longint unsigned wt [0:2][0:2];
		longint prod, q, b;
		longint unsigned r, u, uw, a, p;
		bit bad;
		sample_t s;
		int ax, k, i, j, l, n;
		pin[0] = px;
		pin[1] = py;
		pin[2] = pz;
		bad = 1'b0;
		for (ax = 0; ax < 3; ax++) begin
			pos[ax] = longint'($signed(pin[ax]));
			prod = (pos[ax] - longint'($signed(org_q[ax]))) * longint'(inv_q);
			q = prod >>> (2 * FRAC_BITS);
			r = prod & N_FRAC;
			// base node is floor(n - 0.5)
			if (r >= N_HALF) begin
				b = q;
				u = r - N_HALF;
			end else begin
				b = q - 1;
				u = r + N_HALF;
			end
			uw = u >> (2 * FRAC_BITS - WEIGHT_BITS);
			a = W_ONE - uw;
			wt[ax][0] = (uw == 0) ? (W_ONE >> 1) : ((a * a) >> (WEIGHT_BITS + 1));
			wt[ax][2] = (uw * uw) >> (WEIGHT_BITS + 1);
			wt[ax][1] = W_ONE - wt[ax][0] - wt[ax][2];
			for (k = 0; k < 3; k++) begin
				idx[ax][k] = b + k;
				np[ax][k] = 0;
				off[ax][k] = 0;
				if (!fits32(idx[ax][k])) begin
					bad = 1'b1;
				end else begin
					np[ax][k] = longint'($signed(org_q[ax])) + idx[ax][k] * longint'(sp_q);
					if (!fits32(np[ax][k])) begin
						bad = 1'b1;
					end else begin
						off[ax][k] = np[ax][k] - pos[ax];
						if (!fits32(off[ax][k]))
							bad = 1'b1;
					end
				end
			end
		end
		s = '0;
		if (bad) begin
			s.oor = 1'b1;
			stencil_q = {stencil_q, s};
		end else begin
			n = 0;
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++)
					for (l = 0; l < 3; l++) begin
						p = (wt[0][i] * wt[1][j]) >> WEIGHT_BITS;
						p = (p * wt[2][l]) >> WEIGHT_BITS;
						if (WEIGHT_BITS >= OUT_WEIGHT_BITS)
							p = p >> (WEIGHT_BITS - OUT_WEIGHT_BITS);
						else
							p = p << (OUT_WEIGHT_BITS - WEIGHT_BITS);
						s.geo[0] = idx[0][i][31:0];
						s.geo[1] = idx[1][j][31:0];
						s.geo[2] = idx[2][l][31:0];
						s.geo[3] = np[0][i][31:0];
						s.geo[4] = np[1][j][31:0];
						s.geo[5] = np[2][l][31:0];
						s.geo[6] = off[0][i][31:0];
						s.geo[7] = off[1][j][31:0];
						s.geo[8] = off[2][l][31:0];
						s.wgt = p[OUT_WEIGHT_BITS:0];
						s.lst = (n == STENCIL - 1);
						s.oor = 1'b0;
						stencil_q = {stencil_q, s};
						n++;
					end
		end
	endtask

	function automatic logic [31:0] pick_coord(input logic [31:0] org, input logic [30:0] sp,
			input int spread);
		int mode;
		mode = $urandom_range(99);
		if (mode < 70)
			return org + $urandom_range(0, (32'd1 << (spread + 1)) - 1) - (32'd1 << spread);
		else if (mode < 85)
			return $urandom;
		else if (mode < 95)
			return ($urandom_range(1) ? 32'h7FFF_0000 : 32'h8000_0000) +
				$urandom_range(0, 32'h3_FFFF);
		// on a node or halfway between two
		return org + (int'($urandom_range(0, 16)) - 8) * int'(sp >> 1);
	endfunction

	task automatic offer(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// drop valid, wait for every word and let the pipeline run empty
	task automatic settle();
		in_valid <= 1'b0;
		while (stencil_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_regs(input phase_t ph);
		logic [31:0] val;
		int ri;
		for (ri = REG_ORIGIN_X; ri <= REG_INV_SPACING; ri++) begin
			case (ri[CFG_IDX_W-1:0])
				REG_ORIGIN_X: val = ph.ox;
				REG_ORIGIN_Y: val = ph.oy;
				REG_ORIGIN_Z: val = ph.oz;
				REG_SPACING: val = {1'b0, ph.sp};
				default: val = {1'b0, ph.inv};
			endcase
			cfg_we <= 1'b1;
			cfg_idx <= ri[CFG_IDX_W-1:0];
			cfg_data <= val;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		org_q[0] = ph.ox;
		org_q[1] = ph.oy;
		org_q[2] = ph.oz;
		sp_q = ph.sp;
		inv_q = ph.inv;
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_words
		sample_t got, want;
		int f;
		if (arst_n && out_valid && !out_stall) begin
			got.geo[0] = node_ix;
			got.geo[1] = node_iy;
			got.geo[2] = node_iz;
			got.geo[3] = node_px;
			got.geo[4] = node_py;
			got.geo[5] = node_pz;
			got.geo[6] = offset_x;
			got.geo[7] = offset_y;
			got.geo[8] = offset_z;
			got.wgt = weight;
			got.lst = last;
			got.oor = out_of_range;
			if (stencil_q.size() == 0) begin
				$display("%0t: word with none expected: node_ix %h weight %h out_of_range %b",
					$time, node_ix, weight, out_of_range);
				errors++;
			end else begin
				want = stencil_q.pop_front();
				for (f = 0; f < 9; f++)
					if (got.geo[f] !== want.geo[f]) begin
						$display("%0t: %s expected %h, got %h", $time, geo_name[f],
							want.geo[f], got.geo[f]);
						errors++;
					end
				if (got.wgt !== want.wgt) begin
					$display("%0t: weight expected %h, got %h", $time, want.wgt, got.wgt);
					errors++;
				end
				if (got.lst !== want.lst) begin
					$display("%0t: last expected %b, got %b", $time, want.lst, got.lst);
					errors++;
				end
				if (got.oor !== want.oor) begin
					$display("%0t: out_of_range expected %b, got %b", $time, want.oor,
						got.oor);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		sample_t flagged;
		phase_t cur;
		logic [31:0] x, y, z;
		int row, ph, it;
		org_q[0] = '0;
		org_q[1] = '0;
		org_q[2] = '0;
		sp_q = 31'd1 << FRAC_BITS;
		inv_q = 31'd1 << FRAC_BITS;
		flagged = '0;
		flagged.oor = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < NUM_ROWS; row++) begin
			offer(DIR_ROWS[row].x, DIR_ROWS[row].y, DIR_ROWS[row].z);
			if (DIR_ROWS[row].kind == ROW_OVERFLOW)
				stencil_q = {stencil_q, flagged};
			else
				compute_stencil(DIR_ROWS[row].x, DIR_ROWS[row].y, DIR_ROWS[row].z);
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			cur = PHASES[ph];
			settle();
			load_regs(cur);
			idle_pct = cur.idle;
			stall_pct = cur.stall;
			for (it = 0; it < cur.items; it++) begin
				// long receiver hold-off while words keep coming, to back up the pipeline
				if (cur.hold && it == 2)
					hold_req++;
				if (cur.pause && it == cur.items / 2)
					settle();
				x = pick_coord(cur.ox, cur.sp, cur.spread);
				y = pick_coord(cur.oy, cur.sp, cur.spread);
				z = pick_coord(cur.oz, cur.sp, cur.spread);
				offer(x, y, z);
				compute_stencil(x, y, z);
			end
		end

		settle();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: bspline_stencil_weights.f
hdl/bsw_pkg.sv
hdl/bsw_axis.sv
hdl/bspline_stencil_weights.sv
hdl/bsw_checker.sv
tb/tb_bspline_stencil_weights.sv
